/* rtl/core/gfse_pkg.sv */
package gfse_pkg;

  // Field prime and largest supported group length.
  localparam logic [7:0] FIELD_PRIME = 8'd251;
  localparam logic [3:0] MAX_GROUP   = 4'd8;

  // Configuration register indexes.
  localparam int         CFG_IW          = 2;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [1:0] CFG_SHARE_COUNT = 2'd1;

  // Configuration reset values.
  localparam logic [3:0] THRESHOLD_RST   = 4'd2;
  localparam logic [3:0] SHARE_COUNT_RST = 4'd4;

  // One classified coefficient handed from front to back.
  typedef struct packed {
    logic [7:0] coef;   // already reduced mod 251
    logic       close;  // last coefficient of its group
    logic [7:0] count;  // effective share count for this group
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [3:0] share_index;
    logic [7:0] share_value;
    logic       last_share;
  } res_t;

  // Reduce a 16-bit value mod 251, using 256 = 5 (mod 251).
  function automatic logic [7:0] red251(input logic [15:0] x);
    logic [10:0] t1;
    logic [8:0]  t2;
    t1 = 11'(x[15:8]) * 11'd5 + 11'(x[7:0]);
    t2 = 9'(t1[10:8]) * 9'd5 + 9'(t1[7:0]);
    if (t2 >= 9'(FIELD_PRIME)) begin
      t2 = t2 - 9'(FIELD_PRIME);
    end
    return t2[7:0];
  endfunction

endpackage

/* rtl/core/gfse_fifo.sv */
module gfse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [NW-1:0]    fill_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill_r == NW'(DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + NW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - NW'(1);
      end
    end
  end

endmodule

/* rtl/core/gfse_front.sv */
module gfse_front import gfse_pkg::*; #(
  parameter int MAX_SHARES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_coefficient,
  output logic              in_full,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [3:0]        cfg_data,
  output cmd_t              cmd,
  output logic              cmd_push,
  input  logic              cmd_full
);

  logic [3:0] threshold_r;
  logic [3:0] share_count_r;
  logic [2:0] pos_r;
  logic [3:0] thr_eff;
  logic [7:0] cnt_eff;
  logic [3:0] taken;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full;
  assign cmd_push  = in_push && !cmd_full;
  assign taken     = {1'b0, pos_r} + 4'd1;

  always_comb begin
    thr_eff = threshold_r;
    if (threshold_r == 4'd0) begin
      thr_eff = 4'd1;
    end else if (threshold_r > MAX_GROUP) begin
      thr_eff = MAX_GROUP;
    end
    cnt_eff = 8'(share_count_r);
    if (share_count_r == 4'd0) begin
      cnt_eff = 8'd1;
    end else if (8'(share_count_r) > 8'(MAX_SHARES)) begin
      cnt_eff = 8'(MAX_SHARES);
    end
  end

  always_comb begin
    cmd.coef  = (in_coefficient >= FIELD_PRIME) ? in_coefficient - FIELD_PRIME
                                                : in_coefficient;
    cmd.close = (taken >= thr_eff);
    cmd.count = cnt_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= THRESHOLD_RST;
      share_count_r <= SHARE_COUNT_RST;
      pos_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_THRESHOLD:   threshold_r   <= cfg_data;
          CFG_SHARE_COUNT: share_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd_push) begin
        pos_r <= cmd.close ? 3'd0 : taken[2:0];
      end
    end
  end

endmodule

/* rtl/core/gfse_back.sv */
module gfse_back import gfse_pkg::*; #(
  parameter int MAX_SHARES = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  output res_t res,
  output logic res_push,
  input  logic res_full
);

  localparam int IW = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;
  localparam int CW = $clog2(MAX_SHARES + 1);

  logic [7:0]            sum_mem [MAX_SHARES];
  logic [7:0]            pow_mem [MAX_SHARES];
  logic [MAX_SHARES-1:0] ent_vld_r;

  logic          busy_r;
  cmd_t          cmd_r;
  logic [CW-1:0] rd_cnt_r;
  logic          s1_vld_r;
  logic [IW-1:0] s1_idx_r;
  logic [7:0]    rd_sum_r;
  logic [7:0]    rd_pow_r;
  logic          rd_ok_r;
  logic          s2_vld_r;
  logic [IW-1:0] s2_idx_r;
  logic [7:0]    s2_sum_r;
  logic [15:0]   s2_cprod_r;
  logic [15:0]   s2_pprod_r;

  logic          emit_c;
  logic          stall_c;
  logic          issue_c;
  logic          done_c;
  logic          start_c;
  logic          wr_en;
  logic [7:0]    cur_sum;
  logic [7:0]    cur_pow;
  logic [7:0]    point;
  logic [7:0]    new_sum;
  logic [7:0]    new_pow;
  logic [7:0]    idx_p1;

  assign emit_c  = s2_vld_r && cmd_r.close && (8'(s2_idx_r) < cmd_r.count);
  assign stall_c = emit_c && res_full;
  assign issue_c = busy_r && (rd_cnt_r != CW'(MAX_SHARES)) && !stall_c;
  assign done_c  = busy_r && (rd_cnt_r == CW'(MAX_SHARES)) && !s1_vld_r && !s2_vld_r;
  assign start_c = !cmd_empty && (!busy_r || done_c);
  assign cmd_pop = start_c;
  assign wr_en   = s2_vld_r && !stall_c;

  // Entries never written read as the cleared values.
  assign cur_sum = rd_ok_r ? rd_sum_r : 8'd0;
  assign cur_pow = rd_ok_r ? rd_pow_r : 8'd1;
  assign point   = 8'(s1_idx_r) + 8'd1;

  assign new_sum = red251(16'(s2_sum_r) + s2_cprod_r);
  assign new_pow = red251(s2_pprod_r);
  assign idx_p1  = 8'(s2_idx_r) + 8'd1;

  always_comb begin
    res.share_index = idx_p1[3:0];
    res.share_value = new_sum;
    res.last_share  = (idx_p1 == cmd_r.count);
  end
  assign res_push = emit_c && !res_full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[s2_idx_r] <= cmd_r.close ? 8'd0 : new_sum;
      pow_mem[s2_idx_r] <= cmd_r.close ? 8'd1 : new_pow;
    end
    if (issue_c) begin
      rd_sum_r <= sum_mem[rd_cnt_r[IW-1:0]];
      rd_pow_r <= pow_mem[rd_cnt_r[IW-1:0]];
      rd_ok_r  <= ent_vld_r[rd_cnt_r[IW-1:0]];
      s1_idx_r <= rd_cnt_r[IW-1:0];
    end
    if (start_c) begin
      cmd_r <= cmd;
    end
    if (!stall_c) begin
      s2_idx_r   <= s1_idx_r;
      s2_sum_r   <= cur_sum;
      s2_cprod_r <= 16'(cmd_r.coef) * 16'(cur_pow);
      s2_pprod_r <= 16'(cur_pow) * 16'(point);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rd_cnt_r  <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      ent_vld_r <= '0;
    end else begin
      if (start_c) begin
        busy_r   <= 1'b1;
        rd_cnt_r <= '0;
      end else if (done_c) begin
        busy_r <= 1'b0;
      end else if (issue_c) begin
        rd_cnt_r <= rd_cnt_r + CW'(1);
      end
      if (!stall_c) begin
        s1_vld_r <= issue_c;
        s2_vld_r <= s1_vld_r;
      end
      if (wr_en) begin
        ent_vld_r[s2_idx_r] <= 1'b1;
      end
    end
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !s1_vld_r && !s2_vld_r)
    else $error("back pipeline holds an entry while idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall_c |=> s2_vld_r && $stable(s2_idx_r))
    else $error("stalled write stage lost its entry");

  a_pop_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !s1_vld_r && !s2_vld_r)
    else $error("new command taken before previous pass drained");

endmodule

/* rtl/core/gf251_share_polynomial_eval.sv */
// Shamir-style share evaluator over GF(251).
//
// Input channel (in_push / in_full / in_coefficient): one coefficient word per
// accepted push, lowest power first, threshold words per group. Values 251 and
// above are reduced mod 251.
// Result channel (out_empty / out_pop / out_*): after the last coefficient of a
// group, one word per share 1..share_count, out_last_share set on the final one.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// threshold, index 1 is share_count; cfg_ready is always high. Write only idle.
//
// Each coefficient walks all MAX_SHARES sum/power entries through one shared
// read / multiply / reduce-and-write pipeline, one entry per cycle while the
// output queue has room; the next coefficient is taken only once the walk drains.
// Reset clears the queues, the group position and the entry valid bits, so all
// sums read as zero and all powers as one; registers return to 2 and 4.
// A stalled receiver fills the output queue; the walk then holds in place,
// the command queue fills and in_full rises. No word is dropped.
module gf251_share_polynomial_eval import gfse_pkg::*; #(
  parameter int MAX_SHARES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_coefficient,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [3:0]        out_share_index,
  output logic [7:0]        out_share_value,
  output logic              out_last_share,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [3:0]        cfg_data
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t             fr_cmd;
  logic             fr_push;
  logic             cq_full;
  logic [CMD_W-1:0] cq_rdata;
  logic             cq_empty;
  logic             bk_pop;
  cmd_t             bk_cmd;
  res_t             bk_res;
  logic             bk_push;
  logic             rq_full;
  logic [RES_W-1:0] rq_rdata;
  res_t             out_word;

  // Front: take coefficients and config, classify group ends.
  gfse_front #(.MAX_SHARES(MAX_SHARES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_coefficient (in_coefficient),
    .in_full        (in_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (fr_cmd),
    .cmd_push       (fr_push),
    .cmd_full       (cq_full)
  );

  // Short command queue decouples front from the entry walk.
  gfse_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .wdata (fr_cmd),
    .full  (cq_full),
    .pop   (bk_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  assign bk_cmd = cmd_t'(cq_rdata);

  // Back: walk sums and powers, emit on group close.
  gfse_back #(.MAX_SHARES(MAX_SHARES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (bk_cmd),
    .cmd_empty (cq_empty),
    .cmd_pop   (bk_pop),
    .res       (bk_res),
    .res_push  (bk_push),
    .res_full  (rq_full)
  );

  // Output queue: hold result words until popped.
  gfse_fifo #(.WIDTH(RES_W), .DEPTH(4)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_push),
    .wdata (bk_res),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign out_word        = res_t'(rq_rdata);
  assign out_share_index = out_word.share_index;
  assign out_share_value = out_word.share_value;
  assign out_last_share  = out_word.last_share;

endmodule
